// ----- rtl/fixed_field_integer_parser_top_macros.svh -----
// Assertion macros for the fixed-field integer parser.
`ifndef FIXED_FIELD_INTEGER_PARSER_TOP_MACROS_SVH
`define FIXED_FIELD_INTEGER_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define FFIP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define FFIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FFIP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FFIP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/ffip_pkg.sv -----
package ffip_pkg;

    localparam int MAX_DIGITS  = 18;
    localparam int ACC_W       = 60;
    localparam int VALUE_W     = 61;
    localparam int COUNT_W     = 5;
    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 3;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_PAST_END  = 3'd1,
        ST_BAD_CHAR  = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_SIGN_ONLY = 3'd4
    } status_t;

endpackage

// ----- rtl/fixed_field_integer_parser_top.sv -----
// Fixed-width integer field reader. Each input beat carries one character of the
// field, left to right, with a past-end flag and a last-character mark; blanks are
// skipped, one leading sign is allowed, and up to eighteen digits accumulate. The
// beat marked last produces one output beat with the signed value and a status
// (ok, past end, bad character, too many digits, sign without digits); the value
// is zero whenever the status is not ok. One character is taken every cycle while no
// closing beat waits on a stalled result register; a character passes through an
// input register and then the multiply-by-ten and add into the accumulator, and the
// closing beat writes its value and status into the result register once that
// register is free. Only a stalled output beat holds the input side back.
`include "fixed_field_integer_parser_top_macros.svh"

module fixed_field_integer_parser_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ffip_pkg::CHAR_W-1:0]       char_code,
    input  logic                              past_end,
    input  logic                              last_char,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [ffip_pkg::VALUE_W-1:0] value,
    output logic [ffip_pkg::STATUS_W-1:0]     status
);
    import ffip_pkg::*;

    // Input register.
    logic                s1_valid_reg;
    logic [CHAR_W-1:0]   s1_char_reg;
    logic                s1_past_reg;
    logic                s1_last_reg;

    // Field state.
    logic [ACC_W-1:0]    acc_reg,   acc_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                sign_reg,  sign_next;
    logic                neg_reg,   neg_next;
    status_t             err_reg,   err_next;

    // Result register.
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  value_reg, value_next;
    status_t             status_reg, status_next;

    logic                s1_fire;
    logic                is_digit;
    logic [3:0]          digit;
    logic [ACC_W-1:0]    acc_times10;
    logic [VALUE_W-1:0]  mag_ext;

    // A beat that closes a field needs the result register free.
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    assign is_digit    = (s1_char_reg >= CH_ZERO) && (s1_char_reg <= CH_NINE);
    assign digit       = 4'(s1_char_reg - CH_ZERO);
    assign acc_times10 = {acc_reg[ACC_W-4:0], 3'b000} + {acc_reg[ACC_W-2:0], 1'b0}
                       + ACC_W'(digit);

    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        sign_next  = sign_reg;
        neg_next   = neg_reg;
        err_next   = err_reg;
        if (s1_past_reg)
        begin
            err_next = ST_PAST_END;
        end
        else if (err_reg == ST_OK && s1_char_reg != CH_SPACE)
        begin
            if ((s1_char_reg == CH_MINUS || s1_char_reg == CH_PLUS) && !sign_reg
                && count_reg == '0)
            begin
                sign_next = 1'b1;
                neg_next  = (s1_char_reg == CH_MINUS);
            end
            else if (is_digit)
            begin
                if (count_reg >= COUNT_W'(MAX_DIGITS))
                begin
                    err_next = ST_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    acc_next   = acc_times10;
                end
            end
            else
            begin
                err_next = ST_BAD_CHAR;
            end
        end
    end

    assign mag_ext = {1'b0, acc_next};

    always_comb
    begin
        status_next = err_next;
        if (err_next == ST_OK && sign_next && count_next == '0)
        begin
            status_next = ST_SIGN_ONLY;
        end
        if (status_next == ST_OK)
        begin
            value_next = neg_next ? (VALUE_W'(0) - mag_ext) : mag_ext;
        end
        else
        begin
            value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            count_reg     <= '0;
            sign_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            err_reg       <= ST_OK;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_fire && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                if (s1_last_reg)
                begin
                    acc_reg   <= '0;
                    count_reg <= '0;
                    sign_reg  <= 1'b0;
                    neg_reg   <= 1'b0;
                    err_reg   <= ST_OK;
                end
                else
                begin
                    acc_reg   <= acc_next;
                    count_reg <= count_next;
                    sign_reg  <= sign_next;
                    neg_reg   <= neg_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_char_reg <= char_code;
            s1_past_reg <= past_end;
            s1_last_reg <= last_char;
        end
        if (s1_fire && s1_last_reg)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    `FFIP_ASSERT_SAME(a_err_value_zero, clk, rst_n,
        out_valid && status_reg != ST_OK, value_reg == '0)
    `FFIP_ASSERT_SAME(a_count_bound, clk, rst_n,
        1'b1, count_reg <= COUNT_W'(MAX_DIGITS))
    `FFIP_ASSERT_NEXT(a_clear_after_last, clk, rst_n,
        s1_fire && s1_last_reg, acc_reg == '0 && count_reg == '0 && !sign_reg)
    `FFIP_ASSERT_NEXT(a_result_after_last, clk, rst_n,
        s1_fire && s1_last_reg, out_valid_reg)

endmodule

// ----- tb/tb_fixed_field_integer_parser_top.sv -----
module tb_fixed_field_integer_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ffip_pkg::*;

    localparam int TOTAL_ITEMS  = 900;
    localparam int CALM_FROM    = 800;
    localparam int HOLD_AT      = 300;
    localparam int PAUSE_AT     = 600;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;

    // Keeps a running copy of the field state and the list of results still owed.
    class field_scoreboard;
        typedef struct {
            logic signed [VALUE_W-1:0] value;
            status_t                   status;
        } field_result_t;

        logic [ACC_W-1:0]   magnitude;
        logic [COUNT_W-1:0] digits;
        bit                 sign_taken;
        bit                 minus;
        status_t            error_so_far;
        field_result_t      expected_fields[$];
        int                 fails;

        function new();
            restart();
            fails = 0;
        endfunction

        function void restart();
            magnitude    = '0;
            digits       = '0;
            sign_taken   = 1'b0;
            minus        = 1'b0;
            error_so_far = ST_OK;
        endfunction

        function int pending();
            return expected_fields.size();
        endfunction

        function void parse_char(logic [CHAR_W-1:0] c, logic past, logic last);
            field_result_t    r;
            logic [VALUE_W-1:0] mag_ext;
            if (past)
            begin
                error_so_far = ST_PAST_END;
            end
            else if (error_so_far == ST_OK && c != CH_SPACE)
            begin
                if ((c == CH_MINUS || c == CH_PLUS) && !sign_taken && digits == 0)
                begin
                    sign_taken = 1'b1;
                    minus      = (c == CH_MINUS);
                end
                else if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    if (digits >= MAX_DIGITS)
                        error_so_far = ST_OVERFLOW;
                    else
                    begin
                        digits++;
                        magnitude = magnitude * 60'd10 + ACC_W'(c - CH_ZERO);
                    end
                end
                else
                    error_so_far = ST_BAD_CHAR;
            end
            if (last)
            begin
                r.status = error_so_far;
                if (r.status == ST_OK && sign_taken && digits == 0)
                    r.status = ST_SIGN_ONLY;
                r.value = '0;
                if (r.status == ST_OK)
                begin
                    mag_ext = {1'b0, magnitude};
                    r.value = minus ? -mag_ext : mag_ext;
                end
                expected_fields.push_back(r);
                restart();
            end
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] got_value,
                                   logic [STATUS_W-1:0] got_status);
            field_result_t exp_r;
            if (expected_fields.size() == 0)
            begin
                $error("result beat with no field pending: value %0d status %0d",
                       got_value, got_status);
                fails++;
                return;
            end
            exp_r = expected_fields.pop_front();
            if (got_value !== exp_r.value)
            begin
                $error("value: expected %0d, actual %0d", exp_r.value, got_value);
                fails++;
            end
            if (got_status !== exp_r.status)
            begin
                $error("status: expected %0d, actual %0d", exp_r.status, got_status);
                fails++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [CHAR_W-1:0]          char_code;
    logic                       past_end;
    logic                       last_char;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0]        status;

    field_scoreboard sb = new();

    logic [CHAR_W-1:0] fld_chars[$];
    bit                fld_past[$];
    int                sent;
    int                idle_cycles;
    bit                calm;
    bit                hold_req;

    fixed_field_integer_parser_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .past_end  (past_end),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Both handshakes are observed here, and the watchdog runs off the same edges.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.parse_char(char_code, past_end, last_char);
            if (out_valid && out_ready)
                sb.check_result(value, status);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Output side: random stall bursts, one long hold-off on request, none when calm.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    function automatic void put_char(logic [CHAR_W-1:0] c, bit p);
        fld_chars.push_back(c);
        fld_past.push_back(p);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i], 1'b0);
    endfunction

    function automatic void put_number(int ndig);
        int dstyle;
        dstyle = $urandom_range(0, 5);
        repeat ($urandom_range(0, 3)) put_char(CH_SPACE, 1'b0);
        case ($urandom_range(0, 2))
            1: put_char(CH_PLUS, 1'b0);
            2: put_char(CH_MINUS, 1'b0);
            default: ;
        endcase
        for (int i = 0; i < ndig; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                put_char(CH_SPACE, 1'b0);
            case (dstyle)
                0: put_char(CH_NINE, 1'b0);
                1: put_char(CH_ZERO, 1'b0);
                default: put_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)), 1'b0);
            endcase
        end
        repeat ($urandom_range(0, 2)) put_char(CH_SPACE, 1'b0);
    endfunction

    function automatic int some_digits();
        return ($urandom_range(0, 3) == 0) ? MAX_DIGITS : $urandom_range(1, MAX_DIGITS);
    endfunction

    function automatic void random_field();
        int kind;
        int idx;
        kind = $urandom_range(0, 99);
        if (kind < 55)
            put_number(some_digits());
        else if (kind < 65)
            put_number($urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 3));
        else if (kind < 73)
        begin
            put_number(some_digits());
            idx = $urandom_range(0, fld_chars.size() - 1);
            fld_chars[idx] = CHAR_W'($urandom_range(0, 255));
        end
        else if (kind < 81)
        begin
            // The record ends somewhere inside the field; every later column is past it.
            put_number(some_digits());
            idx = $urandom_range(0, fld_chars.size() - 1);
            for (int i = idx; i < fld_past.size(); i++)
                fld_past[i] = 1'b1;
        end
        else if (kind < 87)
        begin
            case ($urandom_range(0, 4))
                0: put_text("+");
                1: put_text(" - ");
                2: put_text("+-5");
                3: put_text("5+");
                default: put_text("--");
            endcase
        end
        else if (kind < 93)
            repeat ($urandom_range(1, 5)) put_char(CH_SPACE, 1'b0);
        else
            repeat ($urandom_range(1, 6))
                put_char(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // with valid still high so the next character can follow without a gap.
    task automatic send_char(logic [CHAR_W-1:0] c, logic p, logic l);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid  = 1'b1;
        char_code = c;
        past_end  = p;
        last_char = l;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_field();
        for (int i = 0; i < fld_chars.size(); i++)
            send_char(fld_chars[i], fld_past[i], i == fld_chars.size() - 1);
        fld_chars.delete();
        fld_past.delete();
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        bit held;
        bit paused;
        held        = 1'b0;
        paused      = 1'b0;
        sent        = 0;
        idle_cycles = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        char_code   = '0;
        past_end    = 1'b0;
        last_char   = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Short hand-picked fields first.
        put_text(" ");      send_field();
        put_text("+");      send_field();
        put_text("-7");     send_field();
        put_text("1-");     send_field();
        put_text("+-");     send_field();
        put_char(8'hFF, 1'b0); send_field();
        put_char(8'h00, 1'b0); send_field();
        put_text("x");
        put_char(CH_SPACE, 1'b1);
        send_field();
        put_text(" 0 ");    send_field();
        put_text("+9 9");   send_field();

        while (sent < TOTAL_ITEMS)
        begin
            if (!held && sent >= HOLD_AT)
            begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && sent >= PAUSE_AT)
            begin
                paused   = 1'b1;
                in_valid = 1'b0;
                wait_drained();
            end
            calm = (sent >= CALM_FROM);
            random_field();
            send_field();
        end
        in_valid = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ffip_pkg.sv
rtl/fixed_field_integer_parser_top.sv
tb/tb_fixed_field_integer_parser_top.sv
